// ----- hw/rtl/scfp_pkg.sv -----
`default_nettype none

package scfp_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int FRAC_DIGITS = 4;

    localparam int FC_W    = $clog2(FRAME_BYTES);
    localparam int SCALE   = 10 ** FRAC_DIGITS;
    localparam int MAG_MAX = 2147483647;
    localparam int INT_CAP = MAG_MAX / SCALE + 1;
    localparam int INT_W   = $clog2(INT_CAP + 1);
    localparam int FRAC_W  = $clog2(SCALE);
    localparam int CNT_W   = $clog2(FRAC_DIGITS + 1);
    localparam int MAG_W   = 34;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] SPEED_TAG [4] = '{8'h52, 8'h50, 8'h4D, 8'h3A}; // RPM:
    localparam logic [7:0] STEER_TAG [4] = '{8'h53, 8'h54, 8'h52, 8'h3A}; // STR:

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } t_phase;

    // weight of the kept fraction digits: 10^(FRAC_DIGITS - cnt)
    function automatic logic [31:0] frac_weight(input logic [CNT_W-1:0] cnt);
        logic [31:0] w;
        w = 32'd1;
        for (int i = 0; i < FRAC_DIGITS; i++) begin
            if (i >= int'(cnt)) begin
                w = w * 32'd10;
            end
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/serial_command_frame_parser.sv -----
`default_nettype none
// Serial command frame parser.
// Input channel: i_rx_valid / o_rx_ready / i_rx_byte, one received byte per transfer.
// Output channel: o_res_valid / i_res_ready / o_target / o_value_e4, one transfer per
// complete "#RPM:<num>;;" or "#STR:<num>;;" frame. o_target is 0 for speed, 1 for
// steering; o_value_e4 is the number times 10^4, truncated toward zero, saturated.
// Frames with an unknown prefix, frames cut short by a new '#', and overlong frames
// give no result. Bytes outside a frame are dropped.
// The result of the closing ';' goes through the input register, then one pass of
// parse logic into the result register. Throughput: one byte per cycle, set by the
// single parse pass on the input register, but for the stall described next.
// A byte that closes a frame waits in the input register while the result register
// is still full; the receiver stalling thus backs up the input channel only then.
// Reset (synchronous, active low) empties both registers and closes any open frame.
module serial_command_frame_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic             o_target,
    output logic [31:0]      o_value_e4
);
    import scfp_pkg::*;

    logic              r_in_vld;
    logic [7:0]        r_in_byte;

    logic [FC_W-1:0]   r_count,   n_count;
    logic              r_semi,    n_semi;
    logic              r_spd_ok,  n_spd_ok;
    logic              r_str_ok,  n_str_ok;
    t_phase            r_phase,   n_phase;
    logic              r_neg,     n_neg;
    logic [INT_W-1:0]  r_int,     n_int;
    logic [FRAC_W-1:0] r_frac,    n_frac;
    logic [CNT_W-1:0]  r_fcnt,    n_fcnt;

    logic              r_out_vld;
    logic              r_target;
    logic [31:0]       r_value;

    logic              c_digit, c_ws, c_sign;
    logic [INT_W+3:0]  int_next;
    logic [FRAC_W-1:0] weight;
    logic [MAG_W-1:0]  mag;
    logic [31:0]       mag_sat;
    logic              ends, res, adv;
    logic [1:0]        tag_idx;
    logic [7:0]        c;

    assign c       = r_in_byte;
    assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign c_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign c_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign tag_idx = 2'(r_count - FC_W'(1));

    assign int_next = (INT_W+4)'(r_int) * (INT_W+4)'(10) + (INT_W+4)'(c[3:0]);

    assign weight  = FRAC_W'(frac_weight(r_fcnt));
    assign mag     = MAG_W'(r_int) * MAG_W'(SCALE) + MAG_W'(r_frac) * MAG_W'(weight);
    assign mag_sat = (mag > MAG_W'(MAG_MAX)) ? 32'(MAG_MAX) : mag[31:0];

    always_comb begin
        n_count  = r_count;
        n_semi   = r_semi;
        n_spd_ok = r_spd_ok;
        n_str_ok = r_str_ok;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_int    = r_int;
        n_frac   = r_frac;
        n_fcnt   = r_fcnt;
        ends     = 1'b0;

        if (c == CH_HASH) begin
            n_count  = FC_W'(1);
            n_semi   = 1'b0;
            n_spd_ok = 1'b1;
            n_str_ok = 1'b1;
            n_phase  = PH_SKIP;
            n_neg    = 1'b0;
            n_int    = '0;
            n_frac   = '0;
            n_fcnt   = '0;
        end else if (r_count == '0) begin
            // no frame open: drop
        end else if (int'(r_count) >= FRAME_BYTES - 1) begin
            n_count = '0;
        end else begin
            n_count = r_count + FC_W'(1);
            if (r_count <= FC_W'(4)) begin
                if (c != SPEED_TAG[tag_idx]) n_spd_ok = 1'b0;
                if (c != STEER_TAG[tag_idx]) n_str_ok = 1'b0;
            end else begin
                case (r_phase)
                    PH_SKIP, PH_SIGN, PH_INT: begin
                        if (r_phase == PH_SKIP && c_ws) begin
                            // skip leading whitespace
                        end else if (r_phase == PH_SKIP && c_sign) begin
                            n_neg   = (c == CH_MINUS);
                            n_phase = PH_SIGN;
                        end else if (c_digit) begin
                            n_int   = (int_next > (INT_W+4)'(INT_CAP)) ?
                                      INT_W'(INT_CAP) : int_next[INT_W-1:0];
                            n_phase = PH_INT;
                        end else if (c == CH_DOT) begin
                            n_phase = PH_FRAC;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_FRAC: begin
                        if (c_digit) begin
                            if (int'(r_fcnt) < FRAC_DIGITS) begin
                                n_frac = FRAC_W'((FRAC_W+4)'(r_frac) * (FRAC_W+4)'(10)
                                                 + (FRAC_W+4)'(c[3:0]));
                                n_fcnt = r_fcnt + CNT_W'(1);
                            end
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            ends   = (c == CH_SEMI) && r_semi;
            n_semi = (c == CH_SEMI);
            if (ends) n_count = '0;
        end
    end

    // a closing ';' leaves the number state as it was, so the value comes from r_*
    assign res = r_in_vld && ends && (n_spd_ok || n_str_ok);
    assign adv = r_in_vld && (!res || !r_out_vld || i_res_ready);

    assign o_rx_ready  = !r_in_vld || adv;
    assign o_res_valid = r_out_vld;
    assign o_target    = r_target;
    assign o_value_e4  = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_vld <= i_rx_valid;
        end
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_semi   <= 1'b0;
            r_spd_ok <= 1'b1;
            r_str_ok <= 1'b1;
            r_phase  <= PH_SKIP;
            r_neg    <= 1'b0;
            r_int    <= '0;
            r_frac   <= '0;
            r_fcnt   <= '0;
        end else if (adv) begin
            r_count  <= n_count;
            r_semi   <= n_semi;
            r_spd_ok <= n_spd_ok;
            r_str_ok <= n_str_ok;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_int    <= n_int;
            r_frac   <= n_frac;
            r_fcnt   <= n_fcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && res) begin
            r_out_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_out_vld <= 1'b0;
        end
        if (adv && res) begin
            r_target <= !n_spd_ok;
            r_value  <= r_neg ? (32'd0 - mag_sat) : mag_sat;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/serial_command_frame_parser_test.sv -----
`timescale 1ns / 100ps

module serial_command_frame_parser_test;
    import scfp_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    // stands for a NUL byte in the directed text, which a string cannot hold
    localparam logic [7:0] NUL_MARK = 8'h60;

    typedef struct packed {
        logic        target;
        logic [31:0] value;
    } t_command;

    typedef enum {
        ROW_PREDICTED,
        ROW_NO_RESULT,
        ROW_SPEED,
        ROW_STEER
    } t_row_kind;

    typedef struct {
        string       text;
        t_row_kind   kind;
        logic [31:0] value;
    } t_row;

    localparam int DIR_ROWS = 26;

    t_row directed_rows [DIR_ROWS] = '{
        '{"#RPM:0;;", ROW_SPEED, 32'd0},
        '{"#STR:-12.5;;", ROW_STEER, -32'sd125000},
        '{"#RPM:999999;;", ROW_SPEED, 32'h7FFF_FFFF},
        '{"#STR:-999999;;", ROW_STEER, 32'h8000_0001},
        '{"#STR:214748.3647;;", ROW_STEER, 32'h7FFF_FFFF},
        '{"#STR:-214748.3648;;", ROW_STEER, 32'h8000_0001},
        '{"#RPM:1.23456789;;", ROW_SPEED, 32'd12345},
        '{"#RPM:0.0001;;", ROW_SPEED, 32'd1},
        '{"#RPM: \t\n\013\014\015+7.;;", ROW_SPEED, 32'd70000},
        '{"#RPM:-0;;", ROW_SPEED, 32'd0},
        '{"#STR:abc;;", ROW_STEER, 32'd0},
        '{"#RPM:;;", ROW_SPEED, 32'd0},
        '{"#RPM:+-3;;", ROW_SPEED, 32'd0},
        '{"#STR:.5;;", ROW_STEER, 32'd5000},
        '{"#STR:4`5;;", ROW_STEER, 32'd40000},
        '{"#RPM:9\377;;", ROW_SPEED, 32'd90000},
        '{"#RPM:5;x;;", ROW_SPEED, 32'd50000},
        '{"#XYZ:5;;", ROW_NO_RESULT, 32'd0},
        '{"#rpm:1;;", ROW_NO_RESULT, 32'd0},
        '{"#RPM;;", ROW_NO_RESULT, 32'd0},
        '{"junk;;\377\200", ROW_NO_RESULT, 32'd0},
        '{"#RPM:12#STR:3;;", ROW_STEER, 32'd30000},
        '{"#RPM:1234567890123456789012345678901234567890123456789012345678;;",
          ROW_NO_RESULT, 32'd0},
        '{"#RPM:1234567890123456789012345678901234567890123456789012345678#STR:2;;",
          ROW_STEER, 32'd20000},
        '{"#RPM:12345678901234567890123456789012345678901234567890123456;;",
          ROW_SPEED, 32'h7FFF_FFFF},
        '{"#STR:  -0031.07009x;;", ROW_PREDICTED, 32'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_res_ready = 1'b0;
    logic        o_rx_ready;
    logic        o_res_valid;
    logic        o_target;
    logic [31:0] o_value_e4;

    t_command    pending_cmds [$];
    logic [7:0]  burst [$];
    int          fault_count = 0;
    int          cycle_count = 0;
    int          items_done = 0;
    bit          calm = 1'b0;

    // frame tracker state
    logic [FC_W-1:0]   frame_len;
    logic              prev_semi;
    logic              speed_match;
    logic              steer_match;
    t_phase            num_phase;
    logic              num_neg;
    logic [INT_W-1:0]  int_acc;
    logic [FRAC_W-1:0] frac_acc;
    logic [CNT_W-1:0]  frac_cnt;

    serial_command_frame_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_target    (o_target),
        .o_value_e4  (o_value_e4)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_res_ready <= calm || ($urandom_range(99) >= 25);
    end

    function automatic void start_frame();
        frame_len   = FC_W'(1);
        prev_semi   = 1'b0;
        speed_match = 1'b1;
        steer_match = 1'b1;
        num_phase   = PH_SKIP;
        num_neg     = 1'b0;
        int_acc     = '0;
        frac_acc    = '0;
        frac_cnt    = '0;
    endfunction

    // Advance the frame tracker by one received byte.
    function automatic void track_byte(input logic [7:0] c, output bit seen,
                                       output bit got, output t_command cmd);
        logic [FC_W-1:0]  pos;
        logic             is_digit;
        logic             is_space;
        logic [3:0]       d;
        logic [31:0]      nxt;
        logic [MAG_W-1:0] weight;
        logic [MAG_W-1:0] mag;
        seen = 1'b1;
        got = 1'b0;
        cmd = '0;
        if (c == CH_HASH) begin
            start_frame();
            return;
        end
        if (frame_len == '0) begin
            seen = 1'b0;
            return;
        end
        // full frame: drop the byte and close
        if (frame_len >= FC_W'(FRAME_BYTES - 1)) begin
            frame_len = '0;
            return;
        end
        pos = frame_len;
        frame_len = frame_len + FC_W'(1);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        d = 4'(c - CH_ZERO);
        if (pos >= 1 && pos <= 4) begin
            if (c != SPEED_TAG[2'(pos - FC_W'(1))]) speed_match = 1'b0;
            if (c != STEER_TAG[2'(pos - FC_W'(1))]) steer_match = 1'b0;
        end else if (pos >= 5 && num_phase != PH_DONE) begin
            if (num_phase == PH_SKIP && is_space) begin
                // hold in leading whitespace
            end else if (num_phase == PH_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
                num_neg = (c == CH_MINUS);
                num_phase = PH_SIGN;
            end else if (num_phase != PH_FRAC) begin
                if (is_digit) begin
                    nxt = 32'(int_acc) * 32'd10 + 32'(d);
                    int_acc = (nxt > 32'(INT_CAP)) ? INT_W'(INT_CAP) : INT_W'(nxt);
                    num_phase = PH_INT;
                end else if (c == CH_DOT) begin
                    num_phase = PH_FRAC;
                end else begin
                    num_phase = PH_DONE;
                end
            end else if (is_digit) begin
                if (frac_cnt < CNT_W'(FRAC_DIGITS)) begin
                    frac_acc = FRAC_W'(32'(frac_acc) * 32'd10 + 32'(d));
                    frac_cnt = frac_cnt + CNT_W'(1);
                end
            end else begin
                num_phase = PH_DONE;
            end
        end
        if (!(c == CH_SEMI && prev_semi)) begin
            prev_semi = (c == CH_SEMI);
            return;
        end
        prev_semi = 1'b1;
        frame_len = '0;
        if (!speed_match && !steer_match) return;
        weight = MAG_W'(1);
        for (int i = int'(frac_cnt); i < FRAC_DIGITS; i++) weight = weight * MAG_W'(10);
        mag = MAG_W'(int_acc) * MAG_W'(SCALE) + MAG_W'(frac_acc) * weight;
        if (mag > MAG_W'(MAG_MAX)) mag = MAG_W'(MAG_MAX);
        got = 1'b1;
        cmd.target = !speed_match;
        cmd.value = num_neg ? 32'd0 - mag[31:0] : mag[31:0];
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit keep);
        bit       seen;
        bit       got;
        t_command cmd;
        while (!calm && $urandom_range(99) < 25) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        track_byte(b, seen, got, cmd);
        if (seen) items_done++;
        if (keep && got) pending_cmds.push_back(cmd);
    endtask

    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] any_but_hash();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_HASH);
        return b;
    endfunction

    function automatic logic [7:0] digit_char();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    task automatic push_number();
        int r;
        r = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (r) begin
            r = $urandom_range(5);
            burst.push_back((r == 5) ? CH_SPACE : CH_TAB + 8'(r));
        end
        r = $urandom_range(5);
        if (r == 0) burst.push_back(CH_PLUS);
        else if (r <= 2) burst.push_back(CH_MINUS);
        r = ($urandom_range(9) == 0) ? $urandom_range(6, 10) : $urandom_range(0, 4);
        repeat (r) burst.push_back(digit_char());
        if ($urandom_range(1)) begin
            burst.push_back(CH_DOT);
            repeat ($urandom_range(0, 7)) burst.push_back(digit_char());
        end
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) burst.push_back(any_but_hash());
        end
    endtask

    // Mostly well-formed frames with random content; the rest broken or noise.
    task automatic random_frame();
        int kind;
        int pick;
        burst.delete();
        kind = $urandom_range(99);
        if (kind < 88) begin
            pick = $urandom_range(1);
            burst.push_back(CH_HASH);
            for (int i = 0; i < 4; i++) begin
                burst.push_back(pick ? STEER_TAG[i] : SPEED_TAG[i]);
            end
            if (kind >= 70 && kind < 78) begin
                pick = $urandom_range(4);
                if (pick < 4) begin
                    burst[1 + pick] = any_but_hash();
                end else begin
                    for (int i = 1; i <= 4; i++) burst[i] = any_but_hash();
                end
            end
            if (kind >= 84) begin
                repeat ($urandom_range(55, 70)) begin
                    burst.push_back($urandom_range(3) == 0 ? any_but_hash() : digit_char());
                end
            end else begin
                push_number();
            end
            // leave the frame open so that the next '#' cuts it
            if (!(kind >= 78 && kind < 84)) begin
                burst.push_back(CH_SEMI);
                burst.push_back(CH_SEMI);
            end
        end else if (kind < 94) begin
            repeat ($urandom_range(1, 6)) burst.push_back(any_but_hash());
        end else begin
            repeat ($urandom_range(5, 20)) burst.push_back(8'($urandom_range(255)));
        end
        foreach (burst[i]) send_byte(burst[i], 1'b1);
    endtask

    always @(posedge i_clk) begin
        t_command want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected result: target %0d value_e4 %0d",
                       o_target, $signed(o_value_e4));
                fault_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (o_target !== want.target) begin
                    $error("target: expected %0d, got %0d", want.target, o_target);
                    fault_count++;
                end
                if (o_value_e4 !== want.value) begin
                    $error("value_e4: expected %0d, got %0d",
                           $signed(want.value), $signed(o_value_e4));
                    fault_count++;
                end
            end
        end
    end

    initial begin
        logic [7:0] b;
        bit         typed;
        int         frame_no;
        start_frame();
        frame_len = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            typed = (directed_rows[r].kind != ROW_PREDICTED);
            for (int i = 0; i < directed_rows[r].text.len(); i++) begin
                b = directed_rows[r].text[i];
                if (b == NUL_MARK) b = 8'h00;
                send_byte(b, !typed);
            end
            if (directed_rows[r].kind == ROW_SPEED || directed_rows[r].kind == ROW_STEER) begin
                pending_cmds.push_back(t_command'{directed_rows[r].kind == ROW_STEER,
                                                  directed_rows[r].value});
            end
        end
        wait_drained();

        frame_no = 0;
        while (items_done < ITEM_TARGET) begin
            calm = (frame_no >= 40 && frame_no < 60);
            if (frame_no == 70) wait_drained();
            random_frame();
            frame_no++;
        end
        calm = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && pending_cmds.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
